[rtl/core/rcbs_pkg.sv]
// Package with types, constants and register codes of the coverage binning smoother.
package rcbs_pkg;

    localparam int BIN_COUNT_DEF  = 1048576;
    localparam int MAX_SMOOTH_DEF = 63;

    localparam logic [63:0] SCALE_NORM = 64'd65536000000;
    localparam logic [47:0] VALUE_MAX  = 48'hFFFF_FFFF_FFFF;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 112;

    localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAG_SHIFT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BINS_USE   = 3'd4;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_DIV,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_Q_MUL,
        ST_Q_SUM,
        ST_Q_DEN,
        ST_Q_NUM,
        ST_Q_DIV,
        ST_Q_RND,
        ST_OUT
    } rcbs_state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } rcbs_div_ctl_t;

endpackage

[rtl/core/rcbs_divider.sv]
// Shared restoring divider, one quotient bit per cycle, 128-bit dividend by 64-bit divisor.
module rcbs_divider
    import rcbs_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  rcbs_div_ctl_t ctl_in,
    input  logic [127:0]  dividend,
    input  logic [63:0]   divisor,
    output logic          busy,
    output logic [127:0]  quotient,
    output logic [64:0]   remainder
);

    logic [127:0] q_reg, q_next;
    logic [64:0]  r_reg, r_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic [64:0]  shifted;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {r_reg[63:0], q_reg[127]};
        if (ctl_in.start) begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, divisor}) begin
                r_next = shifted - {1'b0, divisor};
                q_next = {q_reg[126:0], 1'b1};
            end else begin
                r_next = shifted;
                q_next = {q_reg[126:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd127) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign busy      = busy_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_in.start |-> !ctl_in.busy) else $error("divider restarted while busy");
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_in.start |=> busy_reg && cnt_reg == 7'd0) else $error("divider did not start");
    a_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && cnt_reg == 7'd127 && !ctl_in.start |=> !busy_reg)
        else $error("divider ran too long");
`endif

endmodule

[rtl/core/read_coverage_binning_smoother.sv]
// Top level of the read coverage binning smoother: sequencer, count memory and config.
//
// Channel | Dir | Payload
// s_axis  | in  | tdata: req_type, strand_minus, read_start, read_end, chrom_class, bin_index
// m_axis  | out | tdata: bin_first_base, bin_last_base, smoothed_value; tuser: is_positive
// cfg     | in  | cfg_index, cfg_data: register write
//
// After reset a clearing pass writes zero to every count entry, with s_axis_tready
// low. For an add read the bin index comes from the shared 128-step divider, then
// comes one read-modify-write of the count memory. A query takes the window walk
// (one memory read per cycle), then shift-add multiplication for denominator and
// numerator, then the shared divider.
// A result waits in its output register until m_axis_tready; no new beat meanwhile.
module read_coverage_binning_smoother
    import rcbs_pkg::*;
#(
    parameter int BIN_COUNT  = BIN_COUNT_DEF,
    parameter int MAX_SMOOTH = MAX_SMOOTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [0] req_type, [1] strand_minus, [29:2] read_start, [57:30] read_end,
    // [59:58] chrom_class, [79:60] bin_index
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] bin_first_base, [63:32] bin_last_base, [111:64] smoothed_value
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // is_positive
    output logic                  m_axis_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(BIN_COUNT);
    localparam int LW = $clog2(MAX_SMOOTH + 1);

    // configuration
    logic [12:0] bin_width_reg;
    logic [15:0] frag_shift_reg;
    logic [5:0]  smooth_len_reg;
    logic        normalize_reg;
    logic [20:0] bins_use_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_width_reg  <= 13'd5;
            frag_shift_reg <= 16'd75;
            smooth_len_reg <= 6'd21;
            normalize_reg  <= 1'b1;
            bins_use_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BIN_WIDTH:  bin_width_reg  <= cfg_data[12:0];
                REG_FRAG_SHIFT: frag_shift_reg <= cfg_data[15:0];
                REG_SMOOTH_LEN: smooth_len_reg <= cfg_data[5:0];
                REG_NORMALIZE:  normalize_reg  <= cfg_data[0];
                REG_BINS_USE:   bins_use_reg   <= cfg_data[20:0];
                default: ;
            endcase
        end
    end

    logic [12:0] w_eff;
    logic [26:0] n_eff;
    logic [8:0]  len_eff;
    assign w_eff = (bin_width_reg == 13'd0) ? 13'd1 : bin_width_reg;
    assign n_eff = ({6'd0, bins_use_reg} > 27'(BIN_COUNT)) ? 27'(BIN_COUNT)
                                                           : {6'd0, bins_use_reg};
    assign len_eff = ({3'd0, smooth_len_reg} > 9'(MAX_SMOOTH)) ? 9'(MAX_SMOOTH)
                                                               : {3'd0, smooth_len_reg};

    // count memory
    logic [31:0]   mem [BIN_COUNT];
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wdata, mem_rdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_raddr];
    end

    // sequencer state
    rcbs_state_t state_reg, state_next;
    logic [AW:0]   clr_reg, clr_next;
    logic [31:0]   total_reads_reg, total_reads_next;
    logic [79:0]   item_reg, item_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [8:0]    cnt_reg, cnt_next;
    logic [127:0]  acc_reg, acc_next;
    logic [127:0]  mcand_reg, mcand_next;
    logic [63:0]   mplier_reg, mplier_next;
    logic [63:0]   den_reg, den_next;
    logic          valid_q_reg, valid_q_next;
    logic [31:0]   first_reg, first_next, last_reg, last_next;
    logic [47:0]   value_reg, value_next;
    logic          pos_reg, pos_next;

    // shared divider
    rcbs_div_ctl_t div_ctl;
    logic [127:0]  div_dividend, div_q;
    logic [63:0]   div_divisor;
    logic [64:0]   div_r;
    logic          div_busy;

    rcbs_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    (div_ctl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    logic        in_fire;
    logic        it_type, it_minus;
    logic [27:0] it_start, it_end;
    logic [1:0]  it_class;
    logic [19:0] it_bin;
    logic [29:0] pos_plus;
    logic [29:0] pos_minus;
    logic [8:0]  half_len;
    logic [26:0] win_s;
    logic [127:0] sh_add;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign it_type  = item_reg[0];
    assign it_minus = item_reg[1];
    assign it_start = item_reg[29:2];
    assign it_end   = item_reg[57:30];
    assign it_class = item_reg[59:58];
    assign it_bin   = item_reg[79:60];
    assign pos_plus  = {2'd0, it_start} + {14'd0, frag_shift_reg};
    assign pos_minus = {2'd0, it_end} - {14'd0, frag_shift_reg};
    assign half_len  = len_eff >> 1;
    assign win_s     = {7'd0, it_bin} - {18'd0, half_len};
    assign sh_add    = acc_reg + (mplier_reg[0] ? mcand_reg : 128'd0);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   if (clr_reg == (AW+1)'(BIN_COUNT - 1)) state_next = ST_IDLE;
            ST_IDLE:    if (in_fire) state_next = s_axis_tdata[0] ? ST_Q_SUM : ST_ADD_DIV;
            ST_ADD_DIV: if (!div_busy && !div_ctl.start) state_next = ST_ADD_RD;
            ST_ADD_RD:  state_next = ST_ADD_WR;
            ST_ADD_WR:  state_next = ST_IDLE;
            ST_Q_SUM:   if (!valid_q_reg || cnt_reg == len_eff) state_next = ST_Q_DEN;
            ST_Q_DEN:   if (cnt_reg == 9'd0 && mplier_reg == 64'd0) state_next = ST_Q_MUL;
            ST_Q_MUL:   if (mplier_reg == 64'd0) state_next = ST_Q_NUM;
            ST_Q_NUM:   state_next = ST_Q_DIV;
            ST_Q_DIV:   if (!div_busy && !div_ctl.start) state_next = ST_Q_RND;
            ST_Q_RND:   state_next = ST_OUT;
            ST_OUT:     if (m_axis_tready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        clr_next         = clr_reg;
        total_reads_next = total_reads_reg;
        item_next        = item_reg;
        addr_next        = addr_reg;
        cnt_next         = cnt_reg;
        acc_next         = acc_reg;
        mcand_next       = mcand_reg;
        mplier_next      = mplier_reg;
        den_next         = den_reg;
        valid_q_next     = valid_q_reg;
        first_next       = first_reg;
        last_next        = last_reg;
        value_next       = value_reg;
        pos_next         = pos_reg;
        mem_we           = 1'b0;
        mem_waddr        = addr_reg;
        mem_wdata        = 32'd0;
        mem_raddr        = addr_reg;
        div_ctl          = '{start: 1'b0, busy: div_busy};
        div_dividend     = acc_reg;
        div_divisor      = den_reg;
        s_axis_tready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg[AW-1:0];
                clr_next  = clr_reg + (AW+1)'(1);
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                item_next     = s_axis_tdata;
                cnt_next      = '0;
                acc_next      = '0;
                valid_q_next  = 1'b0;
                if (in_fire && s_axis_tdata[0]) begin
                    first_next = {12'd0, s_axis_tdata[79:60]} * {19'd0, w_eff};
                    last_next  = ({12'd0, s_axis_tdata[79:60]} + 32'd1) * {19'd0, w_eff}
                                 - 32'd1;
                    value_next = '0;
                    pos_next   = 1'b0;
                    valid_q_next = (len_eff != 9'd0) && ({7'd0, s_axis_tdata[79:60]} < n_eff)
                        && (n_eff > {18'd0, len_eff})
                        && ({11'd0, s_axis_tdata[79:60]} >= 31'(len_eff >> 1))
                        && ({7'd0, s_axis_tdata[79:60]} - {18'd0, len_eff >> 1}
                            < n_eff - {18'd0, len_eff});
                end
                if (in_fire && !s_axis_tdata[0]) begin
                    div_ctl.start = 1'b1;
                    den_next      = {51'd0, w_eff};
                    // A position in (-width, 0) still lands in bin 0.
                    if (!s_axis_tdata[1]) begin
                        div_dividend = {98'd0, {2'd0, s_axis_tdata[29:2]}
                                               + {14'd0, frag_shift_reg}};
                    end else if (s_axis_tdata[57:30] >= {12'd0, frag_shift_reg}) begin
                        div_dividend = {100'd0, s_axis_tdata[57:30]
                                                - {12'd0, frag_shift_reg}};
                    end else begin
                        div_dividend = '0;
                    end
                    div_divisor = {51'd0, w_eff};
                    if (s_axis_tdata[59:58] < 2'd2 && total_reads_reg != 32'hFFFF_FFFF) begin
                        total_reads_next = total_reads_reg + 32'd1;
                    end
                end
            end
            ST_ADD_DIV: begin
                addr_next = div_q[AW-1:0];
                mem_raddr = div_q[AW-1:0];
            end
            ST_ADD_RD: ;
            ST_ADD_WR: begin
                if (it_class == 2'd0 && (!it_minus || it_end >= {12'd0, frag_shift_reg}
                        || {14'd0, frag_shift_reg} - {2'd0, it_end} < {17'd0, w_eff})
                        && div_q < {101'd0, n_eff} && mem_rdata != 32'hFFFF_FFFF) begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata + 32'd1;
                end
            end
            ST_Q_SUM: begin
                // Reads issue for offsets cnt = 0..len-1; each read's data arrives in the next cycle.
                mem_raddr = win_s[AW-1:0] + AW'(cnt_reg);
                if (cnt_reg >= 9'd1) acc_next = acc_reg + {96'd0, mem_rdata};
                cnt_next = cnt_reg + 9'd1;
                if (!valid_q_reg || cnt_reg == len_eff) begin
                    // den = len * width * total (just len without normalize), built by shift-add below
                    mcand_next  = {119'd0, len_eff};
                    mplier_next = normalize_reg ? {51'd0, w_eff} : 64'd1;
                    den_next    = '0;
                    cnt_next    = 9'd1;
                end
            end
            ST_Q_DEN: begin
                if (mplier_reg != 64'd0) begin
                    den_next    = den_reg + (mplier_reg[0] ? mcand_reg[63:0] : 64'd0);
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end else if (cnt_reg == 9'd1) begin
                    mcand_next  = {64'd0, den_reg};
                    mplier_next = normalize_reg ? {32'd0, total_reads_reg} : 64'd1;
                    den_next    = '0;
                    cnt_next    = 9'd0;
                end else begin
                    // numerator: acc * mult
                    mcand_next  = acc_reg;
                    mplier_next = normalize_reg ? SCALE_NORM : 64'd65536;
                    den_next    = den_reg;
                    acc_next    = '0;
                end
                if (mplier_reg == 64'd0 && cnt_reg == 9'd0) begin
                    den_next = den_reg;
                end
            end
            ST_Q_MUL: begin
                if (mplier_reg != 64'd0) begin
                    acc_next    = sh_add;
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
            end
            ST_Q_NUM: begin
                if (valid_q_reg && acc_reg != 128'd0 && den_reg != 64'd0) begin
                    div_ctl.start = 1'b1;
                end else begin
                    valid_q_next = 1'b0;
                end
            end
            ST_Q_DIV: ;
            ST_Q_RND: begin
                if (valid_q_reg) begin
                    pos_next = 1'b1;
                    if (div_q > {80'd0, VALUE_MAX}) begin
                        value_next = VALUE_MAX;
                    end else if ({div_r[63:0], 1'b0} >= {1'b0, den_reg}
                                 && div_q[47:0] != VALUE_MAX) begin
                        value_next = div_q[47:0] + 48'd1;
                    end else begin
                        value_next = div_q[47:0];
                    end
                end
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            total_reads_reg <= '0;
        end else begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            total_reads_reg <= total_reads_next;
        end
        item_reg    <= item_next;
        addr_reg    <= addr_next;
        cnt_reg     <= cnt_next;
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        den_reg     <= den_next;
        valid_q_reg <= valid_q_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        value_reg   <= value_next;
        pos_reg     <= pos_next;
    end

    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {value_reg, last_reg, first_reg};
    assign m_axis_tuser  = pos_reg;

    logic unused_ok;
    assign unused_ok = it_type ^ (|pos_plus) ^ (|pos_minus) ^ (|it_start) ^ div_r[64]
                     ^ (|it_class[1]) ^ LW[0];

`ifndef SYNTHESIS
    a_no_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> state_reg == ST_IDLE) else $error("input taken while busy");
    a_pos_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> value_reg == 48'd0)
        else $error("nonzero value without positive flag");
    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && total_reads_reg != $past(total_reads_reg)
        |-> total_reads_reg == $past(total_reads_reg) + 32'd1)
        else $error("total jumped");
`endif

endmodule

[tb/sv/read_coverage_binning_smoother_tb.sv]
// Testbench for the read coverage binning smoother: directed table, random phases, predictor.
module read_coverage_binning_smoother_tb;
    import rcbs_pkg::*;

    localparam int BINS_MAX = 1048576;
    localparam int NEAR_BINS = 250;
    localparam int SETTLE = 400;

    typedef struct {
        bit        req;
        bit        strand;
        bit [27:0] rd_start;
        bit [27:0] rd_stop;
        bit [1:0]  cls;
        bit [19:0] bidx;
    } read_req_t;

    typedef struct {
        bit [31:0] first_base;
        bit [31:0] last_base;
        bit [47:0] value;
        bit        positive;
    } bin_report_t;

    typedef struct {
        read_req_t   item;
        bit          typed;
        bin_report_t want;
    } table_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor state.
    int unsigned bin_tally[int];
    bit [31:0]   read_total;
    bit [12:0]   cur_width;
    bit [15:0]   cur_shift;
    bit [5:0]    cur_smooth;
    bit          cur_norm;
    bit [20:0]   cur_bins;

    bin_report_t pending_reports[$];
    int          err_count;
    bit          calm;
    int          stall_left;

    read_coverage_binning_smoother DUT (.*);

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Updates the coverage state for one accepted beat; returns 1 with a report for a query.
    function automatic bit coverage_predict(input read_req_t it, output bin_report_t rep);
        longint         w, n, len, pos, idx, s, i, sum;
        logic [127:0]   num, den, q, r;
        w = (cur_width == 0) ? 1 : cur_width;
        n = (cur_bins > BINS_MAX) ? BINS_MAX : cur_bins;
        rep = '{default: 0};
        if (!it.req) begin
            if (it.cls > 1) return 0;
            if (read_total != 32'hFFFF_FFFF) read_total++;
            if (it.cls != 0) return 0;
            if (!it.strand) pos = longint'(it.rd_start) + cur_shift;
            else pos = longint'(it.rd_stop) - cur_shift;
            if (pos >= 0) idx = pos / w;
            else if (-pos < w) idx = 0;
            else return 0;
            if (idx < n) begin
                if (!bin_tally.exists(idx)) bin_tally[idx] = 0;
                if (bin_tally[idx] != 32'hFFFF_FFFF) bin_tally[idx]++;
            end
            return 0;
        end
        i = it.bidx;
        len = cur_smooth;
        rep.first_base = 32'(i * w);
        rep.last_base = 32'((i + 1) * w - 1);
        if (len > 0 && i < n && n > len && i >= len / 2) begin
            s = i - len / 2;
            if (s < n - len) begin
                sum = 0;
                for (longint j = 0; j < len; j++)
                    if (bin_tally.exists(s + j)) sum += bin_tally[s + j];
                if (cur_norm) begin
                    num = 128'(sum) * 128'(SCALE_NORM);
                    den = 128'(len) * 128'(w) * 128'(read_total);
                end else begin
                    num = 128'(sum) * 128'd65536;
                    den = 128'(len);
                end
                if (den != 0 && sum > 0) begin
                    q = num / den;
                    r = num % den;
                    if (q > VALUE_MAX) q = VALUE_MAX;
                    else if (2 * r >= den && q < VALUE_MAX) q++;
                    rep.value = q[47:0];
                    rep.positive = 1'b1;
                end
            end
        end
        return 1;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_BIN_WIDTH:  cur_width = val[12:0];
            REG_FRAG_SHIFT: cur_shift = val[15:0];
            REG_SMOOTH_LEN: cur_smooth = val[5:0];
            REG_NORMALIZE:  cur_norm = val[0];
            REG_BINS_USE:   cur_bins = val[20:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic send_item(input read_req_t it, input bit typed, input bin_report_t want);
        int          gap;
        bin_report_t rep;
        gap = gap_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {it.bidx, it.cls, it.rd_stop, it.rd_start, it.strand, it.req};
        do @(posedge aclk); while (!s_axis_tready);
        if (coverage_predict(it, rep))
            pending_reports.insert(pending_reports.size(), typed ? want : rep);
    endtask

    function automatic read_req_t random_item();
        read_req_t it;
        longint    w, pos;
        int        r;
        w = (cur_width == 0) ? 1 : cur_width;
        it.req = ($urandom_range(0, 99) < 35);
        it.strand = 1'($urandom_range(0, 1));
        it.cls = ($urandom_range(0, 9) < 8) ? 2'd0 : 2'($urandom_range(1, 3));
        it.rd_start = 28'($urandom);
        it.rd_stop = 28'($urandom);
        it.bidx = 20'($urandom);
        r = $urandom_range(0, 99);
        if (it.req) begin
            if (r < 85) it.bidx = 20'($urandom_range(0, NEAR_BINS + 70));
        end else if (r < 90) begin
            // Mostly a well-formed read landing in the low bins that the queries look at.
            pos = $urandom_range(0, int'(w) * NEAR_BINS);
            if (r < 10) it.rd_stop = 28'($urandom_range(0, cur_shift));
            else if (it.strand) it.rd_stop = 28'(pos + cur_shift);
            else if (pos >= cur_shift) it.rd_start = 28'(pos - cur_shift);
            else it.rd_start = 28'($urandom_range(0, 300));
        end
        return it;
    endfunction

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 99) < 25) stall_left <= gap_len();
        end
    end

    always @(posedge aclk) begin
        bin_report_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_reports.size() == 0) begin
                $error("result beat with no query outstanding");
                err_count++;
            end else begin
                want = pending_reports.pop_front();
                if (m_axis_tdata[31:0] !== want.first_base) begin
                    $error("bin_first_base expected %0d got %0d", want.first_base,
                           m_axis_tdata[31:0]);
                    err_count++;
                end
                if (m_axis_tdata[63:32] !== want.last_base) begin
                    $error("bin_last_base expected %0d got %0d", want.last_base,
                           m_axis_tdata[63:32]);
                    err_count++;
                end
                if (m_axis_tdata[111:64] !== want.value) begin
                    $error("smoothed_value expected %0d got %0d", want.value,
                           m_axis_tdata[111:64]);
                    err_count++;
                end
                if (m_axis_tuser !== want.positive) begin
                    $error("is_positive expected %0d got %0d", want.positive, m_axis_tuser);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #40000000;
        $display("read_coverage_binning_smoother verification failed");
        $finish;
    end

    initial begin
        table_row_t  rows[$];
        bin_report_t none;
        int unsigned phase_cfg[8][5];

        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        err_count = 0;
        calm = 1'b0;
        stall_left = 0;
        read_total = 0;
        cur_width = 5;
        cur_shift = 75;
        cur_smooth = 21;
        cur_norm = 1'b1;
        cur_bins = 0;
        none = '{default: 0};

        // Reset settings leave no bins in use, so every query reads zero.
        rows = '{
            '{'{1, 0, 0, 0, 0, 20'd0}, 1, '{0, 4, 0, 0}},
            '{'{1, 1, 28'hFFFFFFF, 28'hFFFFFFF, 3, 20'hFFFFF}, 1, '{5242875, 5242879, 0, 0}},
            '{'{0, 0, 0, 0, 0, 0}, 0, none},
            '{'{0, 1, 0, 0, 0, 0}, 0, none},
            '{'{0, 1, 0, 72, 0, 0}, 0, none},
            '{'{0, 1, 0, 74, 0, 0}, 0, none},
            '{'{0, 0, 28'hFFFFFFF, 0, 0, 0}, 0, none},
            '{'{0, 1, 0, 28'hFFFFFFF, 0, 0}, 0, none},
            '{'{0, 0, 100, 0, 1, 0}, 0, none},
            '{'{0, 0, 100, 0, 2, 0}, 0, none},
            '{'{0, 1, 100, 200, 3, 20'hFFFFF}, 0, none},
            '{'{1, 0, 0, 0, 0, 20'd1}, 1, '{5, 9, 0, 0}},
            '{'{1, 0, 0, 0, 0, 20'd10}, 0, none}
        };

        // Bin width, shift, smoothing length, normalize, bins in use.
        phase_cfg = '{
            '{1, 0, 1, 0, 200},
            '{4096, 65535, 63, 1, 300},
            '{0, 10, 0, 0, 100},
            '{7, 75, 5, 1, 2097151},
            '{8191, 300, 2, 0, 1048576},
            '{3, 20, 21, 1, 64},
            '{13, 500, 62, 0, 0},
            '{5, 65535, 9, 1, 180}
        };

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[k]) send_item(rows[k].item, rows[k].typed, rows[k].want);

        for (int p = 0; p < 8; p++) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            drain_results();
            calm = (p % 3 == 2);
            write_reg(REG_BIN_WIDTH, phase_cfg[p][0]);
            write_reg(REG_FRAG_SHIFT, phase_cfg[p][1]);
            write_reg(REG_SMOOTH_LEN, phase_cfg[p][2]);
            write_reg(REG_NORMALIZE, phase_cfg[p][3]);
            write_reg(REG_BINS_USE, phase_cfg[p][4]);
            for (int k = 0; k < 168; k++) send_item(random_item(), 1'b0, none);
        end

        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        drain_results();
        if (err_count == 0)
            $display("read_coverage_binning_smoother verification clean");
        else
            $display("read_coverage_binning_smoother verification failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/rcbs_pkg.sv
rtl/core/rcbs_divider.sv
rtl/core/read_coverage_binning_smoother.sv
tb/sv/read_coverage_binning_smoother_tb.sv
